// ===== hdl/ssc_pkg.sv =====
// shared types and constants of the swing subdivision clock
package ssc_pkg;

   // item on the request channel
   typedef struct packed {
      logic [15:0]        beat_phase;
      logic signed [15:0] swing_eighths_mod;
      logic signed [15:0] swing_sixteenths_mod;
      logic               run_level;
   } req_type;

   // item on the response channel
   typedef struct packed {
      logic beat_out;
      logic eighths_out;
      logic sixteenths_out;
      logic wrap_seen;
   } rsp_type;

   // register port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWING_EIGHTHS    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWING_SIXTEENTHS = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BEAT_GATE        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EIGHTHS_GATE     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIXTEENTHS_GATE  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE_LENGTH     = 3'd5;

   // swing percent range and reset values
   localparam int           PERCENT_BITS     = 7;
   localparam logic [6:0]   SWING_MIN        = 7'd1;
   localparam logic [6:0]   SWING_MAX        = 7'd99;
   localparam logic [6:0]   SWING_RESET      = 7'd50;
   localparam logic [15:0]  PULSE_LEN_RESET  = 16'd48;

   // final swing is percent * 2^15 plus modulation, below 100 * 2^15
   localparam int SWING_FRAC_BITS = 15;
   localparam int SWING_BITS      = 22;

   // divisor 100 * 2^15 = 25 * 2^17
   localparam int DEN_SHIFT = 17;
   localparam int DEN_ODD   = 25;

   // wrap when 20 * |delta| exceeds 19 * full scale
   localparam int WRAP_DEN        = 20;
   localparam int WRAP_NUM        = 19;
   localparam int WRAP_SCALE_BITS = 5;

endpackage

// ===== hdl/swing_subdivision_clock_core.sv =====
// swung x2 / x4 clock multiplier driven by a beat phase
//
// One request item per tick carries the beat phase, two swing modulations and the
// run level; one response item comes back for every request item, carrying the beat,
// eighth and sixteenth output levels and the wrap flag. Both channels use valid and
// stall; an item moves at a clock edge with valid high and stall low.
// The block works one item at a time: req_stall is high from the edge that accepts an
// item until the result has gone into the output register. A tick with a subdivision
// update steps from the wrap check to the final step through the shared multiplier, which
// forms both swing points and the three divisions by 100 * 2^15; a first tick, a wrap or a
// stopped tick goes from the wrap check straight to the final step. If the receiver
// stalls, the result waits in the output register and the block holds its last step
// until the register is free. Registers are written through the csr_ port; the user
// writes them only while no item is in flight, which the block itself does not enforce.
// Synchronous reset restores the register defaults, clears the pulse counters, gate
// levels and previous-phase state; the first item after reset only latches its phase.
module swing_subdivision_clock_core #(
   parameter int PHASE_BITS       = 16,
   parameter int PULSE_COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ssc_pkg::req_type                    req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ssc_pkg::rsp_type                    rsp_item,
   input  logic                                csr_write_enable,
   input  logic [ssc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ssc_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   localparam int PW  = PHASE_BITS;
   localparam int PCB = PULSE_COUNT_BITS;
   localparam int SB  = ssc_pkg::SWING_BITS;
   // dividend after the power-of-two part of the divisor is dropped
   localparam int XB  = PW + SB - ssc_pkg::DEN_SHIFT;
   localparam int WB  = PW + ssc_pkg::WRAP_SCALE_BITS;
   localparam int MA  = XB + 1;
   localparam int MB  = (PW + 2 > SB + 1) ? PW + 2 : SB + 1;
   localparam int PB  = MA + MB;

   localparam logic [63:0] RECIP_WIDE = (64'd1 << XB) / 64'(ssc_pkg::DEN_ODD);
   localparam logic [PW:0] RECIP      = RECIP_WIDE[PW:0];
   localparam logic [PW:0] FULL       = {1'b1, {PW{1'b0}}};
   localparam logic [WB-1:0] WRAP_LIMIT = WB'(ssc_pkg::WRAP_NUM) << PW;

   // sequencer codes
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CHK  = 4'd1;
   localparam logic [3:0] ST_MS16 = 4'd2;
   localparam logic [3:0] ST_D8M  = 4'd3;
   localparam logic [3:0] ST_D8C  = 4'd4;
   localparam logic [3:0] ST_P2   = 4'd5;
   localparam logic [3:0] ST_D2M  = 4'd6;
   localparam logic [3:0] ST_D2C  = 4'd7;
   localparam logic [3:0] ST_D4M  = 4'd8;
   localparam logic [3:0] ST_D4C  = 4'd9;
   localparam logic [3:0] ST_FIN  = 4'd10;

   // registers of the control port
   logic [6:0]  swing8_ff, swing16_ff;
   logic        beat_gate_ff, eighth_gate_ff, sixteenth_gate_ff;
   logic [15:0] pulse_len_ff;

   // sequencer and item state
   logic [3:0]           state_ff, state_in;
   logic [PW-1:0]        phase_ff, prev_phase_ff;
   logic signed [15:0]   m8_ff, m16_ff;
   logic                 run_ff, prev_valid_ff, wrap_ff, sub_ff;
   logic [SB-1:0]        s8_ff, s16_ff;
   logic [PW-1:0]        t8_ff, t2_ff, t4_ff;
   logic [XB-1:0]        div_x_ff;
   logic signed [PB-1:0] prod_ff;
   logic [PCB-1:0]       beat_left_ff, eighth_left_ff, sixteenth_left_ff;
   logic                 eighth_level_ff, sixteenth_level_ff;
   logic                 rsp_valid_ff;
   ssc_pkg::rsp_type     rsp_item_ff, rsp_item_in;

   logic [PW+15:0]       phase_ext;
   logic [PW-1:0]        phase_diff;
   logic [WB-1:0]        diff_scaled;
   logic                 wrap_in, sub_in;
   logic [6:0]           s8_sat, s16_sat, k8, k16;
   logic [PW+SB-1:0]     s8_shift;
   logic [XB-1:0]        x8, x_prod, div_src;
   logic signed [MA-1:0] mul_a;
   logic signed [MB-1:0] mul_b;
   logic [PW-1:0]        q_est, quot;
   logic [XB-1:0]        div_rem;
   logic [PW:0]          t8_rest;
   logic                 fin_go;

   function automatic logic [6:0] swing_sat(input logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (v < ssc_pkg::SWING_MIN) r = ssc_pkg::SWING_MIN;
      else if (v > ssc_pkg::SWING_MAX) r = ssc_pkg::SWING_MAX;
      return r;
   endfunction

   // weight of the modulation: room below or above the base percent
   function automatic logic [6:0] swing_room(input logic [6:0] s, input logic neg);
      return neg ? (s - ssc_pkg::SWING_MIN) : (ssc_pkg::SWING_MAX - s);
   endfunction

   function automatic logic crossed(input logic [PW-1:0] last, input logic [PW-1:0] now,
                                    input logic [PW-1:0] thr);
      return (last < thr && thr <= now) || (last > thr && thr >= now);
   endfunction

   function automatic logic [PCB-1:0] pulse_load(input logic [PCB-1:0] left,
                                                 input logic load,
                                                 input logic [PCB-1:0] len);
      return (load && len > left) ? len : left;
   endfunction

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         swing8_ff         <= ssc_pkg::SWING_RESET;
         swing16_ff        <= ssc_pkg::SWING_RESET;
         beat_gate_ff      <= 1'b0;
         eighth_gate_ff    <= 1'b0;
         sixteenth_gate_ff <= 1'b0;
         pulse_len_ff      <= ssc_pkg::PULSE_LEN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ssc_pkg::CSR_SWING_EIGHTHS:    swing8_ff <= csr_write_data[6:0];
            ssc_pkg::CSR_SWING_SIXTEENTHS: swing16_ff <= csr_write_data[6:0];
            ssc_pkg::CSR_BEAT_GATE:        beat_gate_ff <= csr_write_data[0];
            ssc_pkg::CSR_EIGHTHS_GATE:     eighth_gate_ff <= csr_write_data[0];
            ssc_pkg::CSR_SIXTEENTHS_GATE:  sixteenth_gate_ff <= csr_write_data[0];
            ssc_pkg::CSR_PULSE_LENGTH:     pulse_len_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // phase bits above the phase width are dropped
   assign phase_ext = {{PW{1'b0}}, req_item.beat_phase};

   // wrap test against the previous sample
   assign phase_diff  = (phase_ff >= prev_phase_ff) ? (phase_ff - prev_phase_ff)
                                                    : (prev_phase_ff - phase_ff);
   assign diff_scaled = WB'(phase_diff) * WB'(ssc_pkg::WRAP_DEN);
   assign wrap_in     = prev_valid_ff && (diff_scaled > WRAP_LIMIT);
   assign sub_in      = run_ff && !wrap_in && prev_valid_ff;

   // swing base and modulation weights
   assign s8_sat  = swing_sat(swing8_ff);
   assign s16_sat = swing_sat(swing16_ff);
   assign k8      = swing_room(s8_sat, m8_ff[15]);
   assign k16     = swing_room(s16_sat, m16_ff[15]);

   // dividends with the 2^17 of the divisor shifted out
   assign s8_shift = {s8_ff, {PW{1'b0}}};
   assign x8       = s8_shift[PW+SB-1:ssc_pkg::DEN_SHIFT];
   assign x_prod   = prod_ff[PW+SB-1:ssc_pkg::DEN_SHIFT];
   assign div_src  = (state_ff == ST_D8M) ? x8 : x_prod;
   assign t8_rest  = FULL - {1'b0, t8_ff};

   // division by 25: reciprocal estimate is low by at most one
   assign q_est   = prod_ff[XB+PW-1:XB];
   assign div_rem = div_x_ff - XB'(q_est) * XB'(ssc_pkg::DEN_ODD);
   assign quot    = (div_rem >= XB'(ssc_pkg::DEN_ODD)) ? q_est + PW'(1) : q_est;

   // operand select of the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_CHK: begin
            mul_a = {{(MA-7){1'b0}}, k8};
            mul_b = {{(MB-16){m8_ff[15]}}, m8_ff};
         end
         ST_MS16: begin
            mul_a = {{(MA-7){1'b0}}, k16};
            mul_b = {{(MB-16){m16_ff[15]}}, m16_ff};
         end
         ST_D8M, ST_D2M, ST_D4M: begin
            mul_a = {{(MA-XB){1'b0}}, div_src};
            mul_b = {{(MB-PW-1){1'b0}}, RECIP};
         end
         ST_P2: begin
            mul_a = {{(MA-PW){1'b0}}, t8_ff};
            mul_b = {{(MB-SB){1'b0}}, s16_ff};
         end
         ST_D2C: begin
            mul_a = {{(MA-PW-1){1'b0}}, t8_rest};
            mul_b = {{(MB-SB){1'b0}}, s16_ff};
         end
         default: ;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (req_valid && !req_stall) begin
         phase_ff <= phase_ext[PW-1:0];
         m8_ff    <= req_item.swing_eighths_mod;
         m16_ff   <= req_item.swing_sixteenths_mod;
         run_ff   <= req_item.run_level;
      end
      if (state_ff == ST_CHK) begin
         wrap_ff <= wrap_in;
         sub_ff  <= sub_in;
      end
      if (state_ff == ST_MS16)
         s8_ff <= {s8_sat, {ssc_pkg::SWING_FRAC_BITS{1'b0}}} + prod_ff[SB-1:0];
      if (state_ff == ST_D8M)
         s16_ff <= {s16_sat, {ssc_pkg::SWING_FRAC_BITS{1'b0}}} + prod_ff[SB-1:0];
      if (state_ff == ST_D8M || state_ff == ST_D2M || state_ff == ST_D4M)
         div_x_ff <= div_src;
      if (state_ff == ST_D8C) t8_ff <= quot;
      if (state_ff == ST_D2C) t2_ff <= quot;
      if (state_ff == ST_D4C) t4_ff <= t8_ff + quot;
   end

   // step order of one item
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_CHK;
         ST_CHK:  state_in = sub_in ? ST_MS16 : ST_FIN;
         ST_MS16: state_in = ST_D8M;
         ST_D8M:  state_in = ST_D8C;
         ST_D8C:  state_in = ST_P2;
         ST_P2:   state_in = ST_D2M;
         ST_D2M:  state_in = ST_D2C;
         ST_D2C:  state_in = ST_D4M;
         ST_D4M:  state_in = ST_D4C;
         ST_D4C:  state_in = ST_FIN;
         ST_FIN:  if (fin_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign fin_go    = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);

   // crossings, gate windows and pulse counters of the final step
   logic [PCB+15:0] len_ext;
   logic [PCB-1:0]  len_sat;
   logic            wrap_trig, both_gate, cross8, cross24;
   logic            beat_load, eighth_load, sixteenth_load;
   logic            win8, win16, beat_level;
   logic [PW-1:0]   e1, e2, e3;
   logic [PW:0]     e4;
   logic [PCB-1:0]  beat_loaded, eighth_loaded, sixteenth_loaded;
   logic [PCB-1:0]  beat_left_in, eighth_left_in, sixteenth_left_in;
   logic            eighth_level_in, sixteenth_level_in;

   assign len_ext = {{PCB{1'b0}}, pulse_len_ff};
   assign len_sat = (len_ext > {16'd0, {PCB{1'b1}}}) ? {PCB{1'b1}} : len_ext[PCB-1:0];

   assign wrap_trig = run_ff && wrap_ff;
   assign both_gate = eighth_gate_ff && sixteenth_gate_ff;
   assign cross8    = crossed(prev_phase_ff, phase_ff, t8_ff);
   assign cross24   = crossed(prev_phase_ff, phase_ff, t2_ff) ||
                      crossed(prev_phase_ff, phase_ff, t4_ff);

   assign beat_load      = wrap_trig && !beat_gate_ff;
   assign eighth_load    = (wrap_trig && !eighth_gate_ff) || (sub_ff && !both_gate && cross8);
   assign sixteenth_load = (wrap_trig && !sixteenth_gate_ff) ||
                           (sub_ff && !both_gate && cross8) ||
                           (sub_ff && !sixteenth_gate_ff && cross24);

   assign e1 = t2_ff >> 1;
   assign e2 = t8_ff - ((t8_ff - t2_ff) >> 1);
   assign e3 = t4_ff - ((t4_ff - t8_ff) >> 1);
   assign e4 = FULL - ((FULL - {1'b0, t4_ff}) >> 1);

   assign win8  = (phase_ff < t2_ff) || (phase_ff >= t8_ff && phase_ff < t4_ff);
   assign win16 = (phase_ff < e1) || (phase_ff >= t2_ff && phase_ff < e2) ||
                  (phase_ff >= t8_ff && phase_ff < e3) ||
                  (phase_ff >= t4_ff && {1'b0, phase_ff} < e4);

   assign beat_loaded      = pulse_load(beat_left_ff, beat_load, len_sat);
   assign eighth_loaded    = pulse_load(eighth_left_ff, eighth_load, len_sat);
   assign sixteenth_loaded = pulse_load(sixteenth_left_ff, sixteenth_load, len_sat);

   // beat: gate is the first half of the beat, counter held meanwhile
   always_comb begin
      if (beat_gate_ff) begin
         beat_level   = !phase_ff[PW-1];
         beat_left_in = beat_loaded;
      end else begin
         beat_level   = |beat_loaded;
         beat_left_in = beat_loaded - PCB'(|beat_loaded);
      end
   end

   // eighths: window gate refreshed only on a subdivision tick
   always_comb begin
      if (eighth_gate_ff) begin
         eighth_level_in = sub_ff ? win8 : eighth_level_ff;
         eighth_left_in  = eighth_loaded;
      end else begin
         eighth_level_in = |eighth_loaded;
         eighth_left_in  = eighth_loaded - PCB'(|eighth_loaded);
      end
   end

   // sixteenths
   always_comb begin
      if (sixteenth_gate_ff) begin
         sixteenth_level_in = sub_ff ? win16 : sixteenth_level_ff;
         sixteenth_left_in  = sixteenth_loaded;
      end else begin
         sixteenth_level_in = |sixteenth_loaded;
         sixteenth_left_in  = sixteenth_loaded - PCB'(|sixteenth_loaded);
      end
   end

   always_comb begin
      rsp_item_in.beat_out       = run_ff && beat_level;
      rsp_item_in.eighths_out    = run_ff && eighth_level_in;
      rsp_item_in.sixteenths_out = run_ff && sixteenth_level_in;
      rsp_item_in.wrap_seen      = wrap_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         prev_phase_ff      <= '0;
         prev_valid_ff      <= 1'b0;
         beat_left_ff       <= '0;
         eighth_left_ff     <= '0;
         sixteenth_left_ff  <= '0;
         eighth_level_ff    <= 1'b0;
         sixteenth_level_ff <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fin_go) begin
            prev_phase_ff      <= phase_ff;
            prev_valid_ff      <= 1'b1;
            beat_left_ff       <= beat_left_in;
            eighth_left_ff     <= eighth_left_in;
            sixteenth_left_ff  <= sixteenth_left_in;
            eighth_level_ff    <= eighth_level_in;
            sixteenth_level_ff <= sixteenth_level_in;
            rsp_valid_ff       <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (fin_go) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // an accepted item always starts at the wrap check
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_CHK)
      else $error("accepted item did not start the sequence");

   // reciprocal estimate must leave a remainder below twice the divisor
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_D8C || state_ff == ST_D2C || state_ff == ST_D4C)
      |-> div_rem < XB'(2 * ssc_pkg::DEN_ODD))
      else $error("division remainder out of range");

   // first sixteenth point never passes the eighth point
   a_t2_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_D4M |-> t2_ff <= t8_ff)
      else $error("sixteenth point beyond eighth point");

   // second sixteenth point lies at or after the eighth point
   a_t4_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && sub_ff |-> t4_ff >= t8_ff)
      else $error("second sixteenth point before eighth point");

endmodule
